>>> src/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned FRACTION_BITS = 8;
  localparam int unsigned NUM_W         = 32 + FRACTION_BITS;

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_MIN      = 4'd4,
    CMD_MAX      = 4'd5,
    CMD_TO_INT   = 4'd6,
    CMD_FROM_INT = 4'd7,
    CMD_INC      = 4'd8,
    CMD_DEC      = 4'd9
  } cmd_e;

  typedef struct packed {
    logic        [3:0]  command;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
    logic               divide_by_zero;
  } out_t;

  typedef struct packed {
    logic              valid;
    logic              is_div;
    logic              neg;
    logic [31:0]       rem;
    logic [NUM_W-1:0]  num;
    logic [31:0]       den;
    out_t              res;
  } stage_t;

endpackage

>>> src/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// Decodes an item, computes all non-divide results combinationally and sets up the divider.
// ----------------------------------------------------------------------------
module fpa_front (
  input  logic          valid_i,
  input  fpa_pkg::in_t  item_i,
  output fpa_pkg::stage_t stage_o
);
  import fpa_pkg::*;

  logic signed [31:0] a, b;
  logic signed [63:0] prod;
  logic signed [63:0] prod_sh;
  logic        [31:0] abs_a, abs_b;
  logic        [31:0] val;
  logic               lt, eq, gt;
  cmd_e               cmd;

  assign a       = item_i.operand_a;
  assign b       = item_i.operand_b;
  assign cmd     = cmd_e'(item_i.command);
  assign prod    = a * b;
  assign prod_sh = prod >>> FRACTION_BITS;
  assign abs_a   = a[31] ? 32'(-a) : 32'(a);
  assign abs_b   = b[31] ? 32'(-b) : 32'(b);
  assign lt      = a < b;
  assign eq      = a == b;
  assign gt      = a > b;

  always_comb begin
    unique case (cmd)
      CMD_ADD:      val = 32'(a + b);
      CMD_SUB:      val = 32'(a - b);
      CMD_MUL:      val = prod_sh[31:0];
      CMD_MIN:      val = lt ? a : b;
      CMD_MAX:      val = gt ? a : b;
      CMD_TO_INT:   val = 32'(a >>> FRACTION_BITS);
      CMD_FROM_INT: val = 32'(a <<< FRACTION_BITS);
      CMD_INC:      val = 32'(a + 32'sd1);
      CMD_DEC:      val = 32'(a - 32'sd1);
      default:      val = '0;
    endcase
  end

  always_comb begin
    stage_o                    = '0;
    stage_o.valid              = valid_i;
    stage_o.is_div             = (cmd == CMD_DIV) && (b != 32'sd0);
    stage_o.neg                = a[31] ^ b[31];
    stage_o.rem                = '0;
    stage_o.num                = NUM_W'(abs_a) << FRACTION_BITS;
    stage_o.den                = abs_b;
    stage_o.res.value          = val;
    stage_o.res.a_less         = lt;
    stage_o.res.a_equal        = eq;
    stage_o.res.a_greater      = gt;
    stage_o.res.divide_by_zero = (cmd == CMD_DIV) && (b == 32'sd0);
  end

endmodule

>>> src/fpa_cell.sv
// ----------------------------------------------------------------------------
// fpa_cell
// One restoring-division step: shifts in a numerator bit, emits a quotient bit.
// ----------------------------------------------------------------------------
module fpa_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fpa_pkg::stage_t stage_i,
  output fpa_pkg::stage_t stage_o
);
  import fpa_pkg::*;

  logic [32:0] trial, diff;
  logic        ge;
  logic        valid_q;
  stage_t      stage_d, stage_q;

  assign trial = {stage_i.rem, stage_i.num[NUM_W-1]};
  assign diff  = trial - {1'b0, stage_i.den};
  assign ge    = trial >= {1'b0, stage_i.den};

  always_comb begin
    stage_d     = stage_i;
    stage_d.rem = ge ? diff[31:0] : trial[31:0];
    stage_d.num = {stage_i.num[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_d.valid;
    end
  end

  // payload needs no reset; only the valid bit is cleared
  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end

endmodule

>>> src/fixed_point_alu_unit.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_unit
// Signed Q fixed-point ALU; divide runs through a row of one-bit cells.
// ----------------------------------------------------------------------------
// channel  | ports                    | handshake
// input    | start_i, busy_o, item_i  | taken when start_i && !busy_o
// result   | done_o, result_o         | one-cycle strobe, cannot stall
//
// One item per cycle; every command runs the same chain, so results leave in
// order after passing the divider cells, one quotient bit per cell, and the
// result register. busy_o stays low. Reset clears the valid bits of the chain
// and the result strobe.
module fixed_point_alu_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  fpa_pkg::in_t  item_i,
  output logic          done_o,
  output fpa_pkg::out_t result_o
);
  import fpa_pkg::*;

  localparam int unsigned LATENCY = NUM_W + 1;

  stage_t chain [NUM_W+1];
  logic   done_q;
  out_t   res_q, res_d;
  logic [31:0] quot;

  assign busy_o = 1'b0;

  fpa_front u_front (
    .valid_i (start_i && !busy_o),
    .item_i  (item_i),
    .stage_o (chain[0])
  );

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    fpa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  assign quot = chain[NUM_W].num[31:0];

  always_comb begin
    res_d = chain[NUM_W].res;
    if (chain[NUM_W].is_div) begin
      res_d.value = chain[NUM_W].neg ? 32'(-quot) : quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain[NUM_W].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##LATENCY done_o) else $error("result strobe missing");
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.divide_by_zero |-> result_o.value == 32'sd0)
    else $error("divide by zero gave nonzero value");
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $onehot({result_o.a_less, result_o.a_equal, result_o.a_greater}))
    else $error("compare flags not one-hot");
  a_no_spur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(chain[NUM_W].valid)) else $error("spurious result");
`endif

endmodule
